// ===== sv/wsp_pkg.sv =====
package wsp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int VP_W          = 14;
  localparam int NEAR_W        = 31;
  localparam int NDC_BITS      = 40;
  localparam int CFG_IDX_W     = 2;
  localparam int IN_TDATA_W    = 136;
  localparam int OUT_TDATA_W   = 64;

  localparam logic [VP_W-1:0]   WIDTH_RST  = 14'd1920;
  localparam logic [VP_W-1:0]   HEIGHT_RST = 14'd1080;
  localparam logic [NEAR_W-1:0] NEAR_RST   = 31'd6554;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_NEAR   = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_PROJECT = 1'b1
  } cmd_e;

  typedef struct packed {
    logic vis;
    logic neg_x;
    logic neg_y;
    logic sat_x;
    logic sat_y;
  } div_ctl_t;

endpackage

// ===== sv/wsp_clip.sv =====
module wsp_clip
  import wsp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int CLIP_W    = 66 - FRAC_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     in_valid_i,
  input  cmd_e                     cmd_i,
  input  logic [3:0]               coef_index_i,
  input  logic signed [COORD_W-1:0] coef_value_i,
  input  logic signed [COORD_W-1:0] pos_x_i,
  input  logic signed [COORD_W-1:0] pos_y_i,
  input  logic signed [COORD_W-1:0] pos_z_i,
  output logic                     valid_o,
  output logic signed [CLIP_W-1:0] cx_o,
  output logic signed [CLIP_W-1:0] cy_o,
  output logic signed [CLIP_W-1:0] cw_o
);

  localparam int PROD_W = 2 * COORD_W;
  localparam int SH_W   = PROD_W - FRAC_BITS;

  logic signed [COORD_W-1:0] matrix_q [16];
  logic signed [PROD_W-1:0]  prod_q [3][3];
  logic signed [PROD_W-1:0]  prod_d [3][3];
  logic signed [COORD_W-1:0] trans_q [3];
  logic signed [CLIP_W-1:0]  sum_d [3];
  logic signed [CLIP_W-1:0]  sum_q [3];
  logic                      v1_q;
  logic                      v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) matrix_q[i] <= '0;
    end else if (in_valid_i && cmd_i == CMD_LOAD) begin
      matrix_q[coef_index_i] <= coef_value_i;
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_row
    localparam int R = (j == 2) ? 3 : j;
    logic signed [SH_W-1:0] s0, s1, s2;

    always_comb begin
      prod_d[j][0] = pos_x_i * matrix_q[R];
      prod_d[j][1] = pos_y_i * matrix_q[4+R];
      prod_d[j][2] = pos_z_i * matrix_q[8+R];
    end

    // floor shift: drop the fraction bits of the exact product
    assign s0 = $signed(prod_q[j][0][PROD_W-1:FRAC_BITS]);
    assign s1 = $signed(prod_q[j][1][PROD_W-1:FRAC_BITS]);
    assign s2 = $signed(prod_q[j][2][PROD_W-1:FRAC_BITS]);

    assign sum_d[j] = $signed({{(CLIP_W-SH_W){s0[SH_W-1]}}, s0})
                    + $signed({{(CLIP_W-SH_W){s1[SH_W-1]}}, s1})
                    + $signed({{(CLIP_W-SH_W){s2[SH_W-1]}}, s2})
                    + $signed({{(CLIP_W-COORD_W){trans_q[j][COORD_W-1]}}, trans_q[j]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q[j][0] <= prod_d[j][0];
        prod_q[j][1] <= prod_d[j][1];
        prod_q[j][2] <= prod_d[j][2];
        trans_q[j]   <= matrix_q[12+R];
        sum_q[j]     <= sum_d[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i && cmd_i == CMD_PROJECT;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign cx_o    = sum_q[0];
  assign cy_o    = sum_q[1];
  assign cw_o    = sum_q[2];

endmodule

// ===== sv/wsp_div.sv =====
module wsp_div
  import wsp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int CLIP_W    = 66 - FRAC_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [CLIP_W-1:0] cx_i,
  input  logic signed [CLIP_W-1:0] cy_i,
  input  logic signed [CLIP_W-1:0] cw_i,
  input  logic [NEAR_W-1:0]        near_i,
  output logic                     valid_o,
  output div_ctl_t                 ctl_o,
  output logic [NDC_BITS-1:0]      qx_o,
  output logic [NDC_BITS-1:0]      qy_o
);

  localparam int NW = CLIP_W + FRAC_BITS;
  localparam int RW = CLIP_W + 1;

  logic [CLIP_W-1:0] ax, ay, dd;
  logic [NW-1:0]     nx, ny;
  div_ctl_t          ctl_d;

  logic                s_v   [NDC_BITS+1];
  div_ctl_t            s_ctl [NDC_BITS+1];
  logic [CLIP_W-1:0]   s_d   [NDC_BITS+1];
  logic [RW-1:0]       s_rx  [NDC_BITS+1];
  logic [RW-1:0]       s_ry  [NDC_BITS+1];
  logic [NDC_BITS-1:0] s_lx  [NDC_BITS+1];
  logic [NDC_BITS-1:0] s_ly  [NDC_BITS+1];
  logic [NDC_BITS-1:0] s_qx  [NDC_BITS+1];
  logic [NDC_BITS-1:0] s_qy  [NDC_BITS+1];

  always_comb begin
    ax = cx_i[CLIP_W-1] ? CLIP_W'(-cx_i) : cx_i;
    ay = cy_i[CLIP_W-1] ? CLIP_W'(-cy_i) : cy_i;
    dd = cw_i;
    nx = {ax, FRAC_BITS'(0)};
    ny = {ay, FRAC_BITS'(0)};
    ctl_d.vis   = (cw_i > $signed(CLIP_W'(0)))
               && (cw_i >= $signed({{(CLIP_W-NEAR_W){1'b0}}, near_i}));
    ctl_d.neg_x = cx_i[CLIP_W-1];
    ctl_d.neg_y = cy_i[CLIP_W-1];
    // quotient would reach 2^40: clamp
    ctl_d.sat_x = CLIP_W'(nx[NW-1:NDC_BITS]) >= dd;
    ctl_d.sat_y = CLIP_W'(ny[NW-1:NDC_BITS]) >= dd;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_ctl[0] <= ctl_d;
      s_d[0]   <= dd;
      s_rx[0]  <= RW'(nx[NW-1:NDC_BITS]);
      s_ry[0]  <= RW'(ny[NW-1:NDC_BITS]);
      s_lx[0]  <= nx[NDC_BITS-1:0];
      s_ly[0]  <= ny[NDC_BITS-1:0];
      s_qx[0]  <= '0;
      s_qy[0]  <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NDC_BITS; i++) s_v[i] <= 1'b0;
    end else if (en_i) begin
      s_v[0] <= valid_i;
      for (int i = 0; i < NDC_BITS; i++) s_v[i+1] <= s_v[i];
    end
  end

  for (genvar k = 0; k < NDC_BITS; k++) begin : g_step
    logic [RW-1:0] tx, ty, rx_d, ry_d;
    logic          bx, by;

    always_comb begin
      tx   = {s_rx[k][RW-2:0], s_lx[k][NDC_BITS-1-k]};
      ty   = {s_ry[k][RW-2:0], s_ly[k][NDC_BITS-1-k]};
      bx   = tx >= {1'b0, s_d[k]};
      by   = ty >= {1'b0, s_d[k]};
      rx_d = bx ? tx - {1'b0, s_d[k]} : tx;
      ry_d = by ? ty - {1'b0, s_d[k]} : ty;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_ctl[k+1] <= s_ctl[k];
        s_d[k+1]   <= s_d[k];
        s_rx[k+1]  <= rx_d;
        s_ry[k+1]  <= ry_d;
        s_lx[k+1]  <= s_lx[k];
        s_ly[k+1]  <= s_ly[k];
        s_qx[k+1]  <= {s_qx[k][NDC_BITS-2:0], bx};
        s_qy[k+1]  <= {s_qy[k][NDC_BITS-2:0], by};
      end
    end
  end

  assign valid_o = s_v[NDC_BITS];
  assign ctl_o   = s_ctl[NDC_BITS];
  assign qx_o    = s_qx[NDC_BITS];
  assign qy_o    = s_qy[NDC_BITS];

endmodule

// ===== sv/wsp_view.sv =====
module wsp_view
  import wsp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  div_ctl_t                  ctl_i,
  input  logic [NDC_BITS-1:0]       qx_i,
  input  logic [NDC_BITS-1:0]       qy_i,
  input  logic [VP_W-1:0]           width_i,
  input  logic [VP_W-1:0]           height_i,
  output logic                      valid_o,
  output logic                      visible_o,
  output logic signed [COORD_W-1:0] screen_x_o,
  output logic signed [COORD_W-1:0] screen_y_o
);

  localparam int HALF_W = VP_W - 1;
  localparam int NDC_W  = NDC_BITS + 2;
  localparam int PW     = HALF_W + 1 + NDC_W;
  localparam int SW     = PW + 1;

  logic [HALF_W-1:0]       hw, hh;
  logic [NDC_BITS:0]       mx, my;
  logic signed [NDC_W-1:0] ndx, ndy;
  logic signed [PW-1:0]    px_d, py_d, px_q, py_q;
  logic                    va_q, vis_a_q;
  logic signed [SW-1:0]    bx, by, sx, sy;
  logic signed [COORD_W-1:0] sx_d, sy_d, sx_q, sy_q;
  logic                    vb_q, vis_q;

  always_comb begin
    hw   = width_i[VP_W-1:1];
    hh   = height_i[VP_W-1:1];
    mx   = ctl_i.sat_x ? {1'b1, NDC_BITS'(0)} : {1'b0, qx_i};
    my   = ctl_i.sat_y ? {1'b1, NDC_BITS'(0)} : {1'b0, qy_i};
    ndx  = ctl_i.neg_x ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
    ndy  = ctl_i.neg_y ? -$signed({1'b0, my}) : $signed({1'b0, my});
    px_d = $signed({1'b0, hw}) * ndx;
    py_d = $signed({1'b0, hh}) * ndy;
  end

  always_comb begin
    bx = $signed(SW'({hw, FRAC_BITS'(0)}));
    by = $signed(SW'({hh, FRAC_BITS'(0)}));
    sx = bx + $signed({px_q[PW-1], px_q});
    sy = by - $signed({py_q[PW-1], py_q});
    if (&sx[SW-1:COORD_W-1] || ~|sx[SW-1:COORD_W-1]) begin
      sx_d = sx[COORD_W-1:0];
    end else begin
      sx_d = sx[SW-1] ? {1'b1, (COORD_W-1)'(0)} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    if (&sy[SW-1:COORD_W-1] || ~|sy[SW-1:COORD_W-1]) begin
      sy_d = sy[COORD_W-1:0];
    end else begin
      sy_d = sy[SW-1] ? {1'b1, (COORD_W-1)'(0)} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    if (!vis_a_q) begin
      sx_d = '0;
      sy_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q    <= px_d;
      py_q    <= py_d;
      vis_a_q <= ctl_i.vis;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      vis_q   <= vis_a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  assign valid_o    = vb_q;
  assign visible_o  = vis_q;
  assign screen_x_o = sx_q;
  assign screen_y_o = sy_q;

endmodule

// ===== sv/world_to_screen_projection.sv =====
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: points, coefficients; tuser: cmd
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: screen x/y; tuser: visible
// cfg       in   cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// One transaction per cycle while m_axis is not stalled; a point result passes through
// 2 multiply/sum stages, 1 divider setup stage plus 40 at one quotient bit each,
// and 2 viewport stages.
// Loads take effect at once and give no result.
// Reset clears the matrix to zero and the viewport and near-plane registers to their defaults.
// A stalled m_axis freezes the whole pipeline; s_axis_tready follows it.
module world_to_screen_projection
  import wsp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [3:0] coef_index, [35:4] coef_value, [67:36] pos_x, [99:68] pos_y, [131:100] pos_z
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] cmd
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [31:0] screen_x, [63:32] screen_y
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] visible
  output logic                   m_axis_tuser,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [COORD_W-1:0]     cfg_data_i
);

  localparam int CLIP_W = 66 - FRAC_BITS;

  logic [VP_W-1:0]   width_q, height_q;
  logic [NEAR_W-1:0] near_q;
  logic              en, in_acc;
  logic              clip_v, div_v;
  logic signed [CLIP_W-1:0] cx, cy, cw;
  div_ctl_t          ctl;
  logic [NDC_BITS-1:0] qx, qy;
  logic signed [COORD_W-1:0] screen_x, screen_y;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      near_q   <= NEAR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= cfg_data_i[VP_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[VP_W-1:0];
        CFG_NEAR:   near_q   <= cfg_data_i[NEAR_W-1:0];
        default:    ;
      endcase
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign in_acc        = s_axis_tvalid && en;

  wsp_clip #(.FRAC_BITS(FRAC_BITS), .CLIP_W(CLIP_W)) u_clip (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .in_valid_i   (in_acc),
    .cmd_i        (cmd_e'(s_axis_tuser)),
    .coef_index_i (s_axis_tdata[3:0]),
    .coef_value_i ($signed(s_axis_tdata[35:4])),
    .pos_x_i      ($signed(s_axis_tdata[67:36])),
    .pos_y_i      ($signed(s_axis_tdata[99:68])),
    .pos_z_i      ($signed(s_axis_tdata[131:100])),
    .valid_o      (clip_v),
    .cx_o         (cx),
    .cy_o         (cy),
    .cw_o         (cw)
  );

  wsp_div #(.FRAC_BITS(FRAC_BITS), .CLIP_W(CLIP_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (clip_v),
    .cx_i    (cx),
    .cy_i    (cy),
    .cw_i    (cw),
    .near_i  (near_q),
    .valid_o (div_v),
    .ctl_o   (ctl),
    .qx_o    (qx),
    .qy_o    (qy)
  );

  wsp_view #(.FRAC_BITS(FRAC_BITS)) u_view (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (div_v),
    .ctl_i      (ctl),
    .qx_i       (qx),
    .qy_i       (qy),
    .width_i    (width_q),
    .height_i   (height_q),
    .valid_o    (m_axis_tvalid),
    .visible_o  (m_axis_tuser),
    .screen_x_o (screen_x),
    .screen_y_o (screen_y)
  );

  assign m_axis_tdata = {screen_y, screen_x};

endmodule

// ===== sv/wsp_checker.sv =====
module wsp_props (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [63:0]  m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output changed under stall");

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 64'd0)
    else $error("hidden point with nonzero screen data");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind world_to_screen_projection wsp_props u_wsp_props (.*);
